[rtl/fbba_pkg.sv]
package fbba_pkg;

   // field widths
   localparam int BLOCK_W    = 14;
   localparam int OP_W       = 3;
   localparam int STATUS_W   = 2;
   localparam int WORD_W     = 32;
   localparam int BIT_IDX_W  = 5;
   localparam int WORD_IDX_W = BLOCK_W - BIT_IDX_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = BLOCK_W;

   // op codes
   localparam logic [OP_W-1:0] OP_TEST  = 3'd0;
   localparam logic [OP_W-1:0] OP_SET   = 3'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd2;
   localparam logic [OP_W-1:0] OP_FIND  = 3'd3;
   localparam logic [OP_W-1:0] OP_ALLOC = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_START = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_END   = 1'd1;

   localparam logic [BLOCK_W-1:0] SEARCH_START_RST = 14'd1;
   localparam logic [BLOCK_W-1:0] SEARCH_END_RST   = 14'd10237;

   typedef enum logic [1:0] {
      ST_CLEARING,
      ST_IDLE,
      ST_RMW,
      ST_SCAN
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic capture;
      logic rmw;
      logic scan;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic need_rmw;
      logic need_scan;
      logic scan_done;
   } dp_stat_type;

endpackage

[rtl/fbba_ctrl.sv]
module fbba_ctrl
   import fbba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   output logic        busy
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEARING;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEARING: begin
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               priority if (stat.need_rmw) begin
                  state_in = ST_RMW;
               end else if (stat.need_scan) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_RMW: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_CLEARING: cmd.clear = 1'b1;
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_RMW:  cmd.rmw  = 1'b1;
         ST_SCAN: cmd.scan = 1'b1;
         default: busy = 1'b1;
      endcase
   end

endmodule

[rtl/fbba_dp.sv]
module fbba_dp
   import fbba_pkg::*;
#(
   parameter int MAP_WORDS = 384
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat,
   input  logic [OP_W-1:0]       req_op,
   input  logic [BLOCK_W-1:0]    req_block,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output logic                  rsp_valid,
   output logic                  rsp_bit_value,
   output logic [BLOCK_W-1:0]    rsp_block_number,
   output logic [STATUS_W-1:0]   rsp_status
);

   localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BlockLimit = MAP_WORDS * WORD_W;
   localparam logic [BLOCK_W-1:0] LimitLow = BLOCK_W'(BlockLimit);
   localparam logic [AW-1:0]      LastAddr = AW'(MAP_WORDS - 1);

   function automatic logic [AW-1:0] word_addr(input logic [WORD_IDX_W-1:0] w);
      logic [AW+WORD_IDX_W-1:0] ext;
      ext = {{AW{1'b0}}, w};
      return ext[AW-1:0];
   endfunction

   // map storage, 1 = used
   logic [WORD_W-1:0] map_mem [MAP_WORDS];

   logic [BLOCK_W-1:0]    search_start_ff;
   logic [BLOCK_W-1:0]    search_end_ff;
   logic [AW-1:0]         clr_ff;
   logic [OP_W-1:0]       op_ff;
   logic [BLOCK_W-1:0]    block_ff;
   logic [WORD_IDX_W-1:0] cur_ff;
   logic [WORD_IDX_W-1:0] cur_in;
   logic [WORD_W-1:0]     rd_data_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_bit_ff;
   logic                  rsp_bit_in;
   logic [BLOCK_W-1:0]    rsp_num_ff;
   logic [BLOCK_W-1:0]    rsp_num_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [STATUS_W-1:0]   rsp_status_in;

   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [WORD_W-1:0]     wr_data;

   // search window
   logic                  end_below_limit;
   logic [BLOCK_W-1:0]    end_clip;
   logic [BLOCK_W-1:0]    last_blk;
   logic                  window_nonempty;
   logic [WORD_IDX_W-1:0] start_word;
   logic [WORD_IDX_W-1:0] last_word;

   // request classification
   logic                  req_in_map;
   logic                  req_bitop;
   logic                  req_findop;

   // word evaluation
   logic [WORD_W-1:0]     blk_mask;
   logic [WORD_W-1:0]     lo_mask;
   logic [WORD_W-1:0]     hi_mask;
   logic [WORD_W-1:0]     free_bits;
   logic                  found;
   logic [BIT_IDX_W-1:0]  found_pos;
   logic                  at_last;

   assign end_below_limit = 32'(search_end_ff) < 32'(BlockLimit);
   assign end_clip        = end_below_limit ? search_end_ff : LimitLow;
   assign window_nonempty = search_start_ff < end_clip;
   assign last_blk        = end_clip - BLOCK_W'(1);
   assign start_word      = search_start_ff[BLOCK_W-1:BIT_IDX_W];
   assign last_word       = last_blk[BLOCK_W-1:BIT_IDX_W];

   assign req_in_map = 32'(req_block) < 32'(BlockLimit);
   assign req_bitop  = (req_op == OP_TEST) || (req_op == OP_SET) || (req_op == OP_CLEAR);
   assign req_findop = (req_op == OP_FIND) || (req_op == OP_ALLOC);

   // block 32*w+k sits at bit 31-k
   assign blk_mask = {1'b1, {(WORD_W-1){1'b0}}} >> block_ff[BIT_IDX_W-1:0];
   assign lo_mask  = (cur_ff == start_word) ?
                     ({WORD_W{1'b1}} >> search_start_ff[BIT_IDX_W-1:0]) : {WORD_W{1'b1}};
   assign hi_mask  = (cur_ff == last_word) ?
                     ~({1'b0, {(WORD_W-1){1'b1}}} >> last_blk[BIT_IDX_W-1:0]) : {WORD_W{1'b1}};
   assign free_bits = ~rd_data_ff & lo_mask & hi_mask;
   assign found     = |free_bits;
   assign at_last   = cur_ff == last_word;

   // lowest free block is the first zero from the msb
   always_comb begin
      found_pos = '0;
      for (int k = WORD_W - 1; k >= 0; k--) begin
         if (free_bits[WORD_W-1-k]) begin
            found_pos = BIT_IDX_W'(k);
         end
      end
   end

   always_comb begin
      stat.clear_last = clr_ff == LastAddr;
      stat.need_rmw   = req_bitop && req_in_map;
      stat.need_scan  = req_findop && window_nonempty;
      stat.scan_done  = found || at_last;
   end

   // memory port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = word_addr(req_block[BLOCK_W-1:BIT_IDX_W]);
      cur_in  = cur_ff;
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = '0;
      priority if (cmd.clear) begin
         wr_en = 1'b1;
      end else if (cmd.capture) begin
         rd_en  = 1'b1;
         cur_in = start_word;
         if (req_findop) begin
            rd_addr = word_addr(start_word);
         end
      end else if (cmd.rmw) begin
         wr_addr = word_addr(block_ff[BLOCK_W-1:BIT_IDX_W]);
         wr_en   = (op_ff == OP_SET) || (op_ff == OP_CLEAR);
         wr_data = (op_ff == OP_SET) ? (rd_data_ff | blk_mask) : (rd_data_ff & ~blk_mask);
      end else if (cmd.scan) begin
         if (found) begin
            wr_en   = op_ff == OP_ALLOC;
            wr_addr = word_addr(cur_ff);
            wr_data = rd_data_ff | ({1'b1, {(WORD_W-1){1'b0}}} >> found_pos);
         end else if (!at_last) begin
            rd_en   = 1'b1;
            cur_in  = cur_ff + WORD_IDX_W'(1);
            rd_addr = word_addr(cur_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_addr];
      end
   end

   // result
   always_comb begin
      rsp_valid_in  = 1'b0;
      rsp_bit_in    = 1'b0;
      rsp_num_in    = block_ff;
      rsp_status_in = ST_OK;
      priority if (cmd.capture) begin
         rsp_num_in   = req_block;
         rsp_valid_in = !stat.need_rmw && !stat.need_scan;
         priority if (req_bitop) begin
            rsp_status_in = ST_RANGE;
         end else if (req_findop) begin
            rsp_num_in    = '0;
            rsp_status_in = ST_FULL;
         end else begin
            rsp_status_in = ST_OK;
         end
      end else if (cmd.rmw) begin
         rsp_valid_in = 1'b1;
         rsp_bit_in   = (op_ff == OP_TEST) && ((rd_data_ff & blk_mask) != '0);
      end else if (cmd.scan) begin
         rsp_valid_in = stat.scan_done;
         if (found) begin
            rsp_num_in = {cur_ff, found_pos};
         end else begin
            rsp_num_in    = '0;
            rsp_status_in = ST_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_start_ff <= SEARCH_START_RST;
         search_end_ff   <= SEARCH_END_RST;
         clr_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_SEARCH_START: search_start_ff <= csr_wr_data;
               CSR_SEARCH_END:   search_end_ff   <= csr_wr_data;
               default:          search_start_ff <= search_start_ff;
            endcase
         end
         if (cmd.clear) begin
            clr_ff <= clr_ff + AW'(1);
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         block_ff <= req_block;
      end
      cur_ff        <= cur_in;
      rsp_bit_ff    <= rsp_bit_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bit_value    = rsp_bit_ff;
   assign rsp_block_number = rsp_num_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

[rtl/free_block_bitmap_allocator.sv]
// sequence: test, set and clear read the map word into a register, then use it and strobe;
//    out-of-range, unused ops and an empty window strobe from the request alone; find and
//    allocate scan one map word per cycle until a free bit or the window's last word
// throughput: test/set/clear and find/allocate hold busy high; others one item per cycle
// reset: synchronous, clears all MAP_WORDS map words in one pass, busy high meanwhile
// the result strobe lasts one cycle and the receiver cannot stall it
module free_block_bitmap_allocator
   import fbba_pkg::*;
#(
   parameter int MAP_WORDS = 384
) (
   input  logic                  clock,
   input  logic                  reset,
   // item request
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_op,
   input  logic [BLOCK_W-1:0]    req_block,
   // result
   output logic                  rsp_valid,
   output logic                  rsp_bit_value,
   output logic [BLOCK_W-1:0]    rsp_block_number,
   output logic [STATUS_W-1:0]   rsp_status,
   // search window registers
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   // command and status between the sequencer and the map datapath
   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer: clearing pass, idle, read-modify-write, word scan
   fbba_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // map memory, window logic, free-bit search and result registers
   fbba_dp #(
      .MAP_WORDS (MAP_WORDS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_op           (req_op),
      .req_block        (req_block),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_bit_value    (rsp_bit_value),
      .rsp_block_number (rsp_block_number),
      .rsp_status       (rsp_status)
   );

endmodule

[sim/testbench.sv]
module testbench;
   import fbba_pkg::*;

   localparam int MAP_WORDS  = 384;
   localparam int MAP_BLOCKS = MAP_WORDS * 32;
   localparam int BLOCK_MAX  = (1 << BLOCK_W) - 1;
   localparam int SETTLE     = 4;     // idle cycles before a register write
   localparam int DRAIN_WAIT = 20;    // cycles after the last result
   localparam int STALL_MAX  = 5000;  // cycles with no traffic before giving up

   typedef enum logic [1:0] {
      E_ITEM,
      E_CSR,
      E_DRAIN
   } cmd_kind_type;

   typedef struct {
      cmd_kind_type          kind;
      logic [OP_W-1:0]       op;
      logic [BLOCK_W-1:0]    blk;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      int unsigned           gap;
   } alloc_cmd_type;

   typedef struct packed {
      logic                bit_value;
      logic [BLOCK_W-1:0]  block_number;
      logic [STATUS_W-1:0] status;
   } bitmap_answer_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [OP_W-1:0]       req_op = '0;
   logic [BLOCK_W-1:0]    req_block = '0;
   logic                  rsp_valid;
   logic                  rsp_bit_value;
   logic [BLOCK_W-1:0]    rsp_block_number;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   alloc_cmd_type     alloc_cmds[$];
   bitmap_answer_type bitmap_answers[$];

   // shadow copy of the map and the search window
   logic [31:0]        shadow_map [MAP_WORDS];
   logic [BLOCK_W-1:0] shadow_lo;
   logic [BLOCK_W-1:0] shadow_hi;

   int unsigned items_sent;
   int unsigned items_done;
   int unsigned errors = 0;
   int unsigned idle_cnt;
   int unsigned quiet_cnt;
   int unsigned stall_cnt;

   // stimulus generation state
   bit          burst = 1'b0;
   int unsigned gen_lo = 1;
   int unsigned gen_hi = 10237;

   free_block_bitmap_allocator #(
      .MAP_WORDS(MAP_WORDS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_block       (req_block),
      .rsp_valid       (rsp_valid),
      .rsp_bit_value   (rsp_bit_value),
      .rsp_block_number(rsp_block_number),
      .rsp_status      (rsp_status),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic block_used(int unsigned b);
      return shadow_map[b >> 5][31 - (b & 31)];
   endfunction

   // applies one item to the shadow map and returns its answer
   function automatic bitmap_answer_type bitmap_apply(logic [OP_W-1:0] op,
                                                      logic [BLOCK_W-1:0] blk);
      bitmap_answer_type a;
      int unsigned       b;
      int unsigned       lim;
      int unsigned       hit_at;
      bit                hit;
      a.bit_value    = 1'b0;
      a.block_number = blk;
      a.status       = ST_OK;
      hit            = 1'b0;
      hit_at         = 0;
      case (op)
         OP_TEST, OP_SET, OP_CLEAR: begin
            if (blk >= MAP_BLOCKS) begin
               a.status = ST_RANGE;
            end else if (op == OP_TEST) begin
               a.bit_value = block_used(blk);
            end else begin
               shadow_map[blk >> 5][31 - blk[4:0]] = (op == OP_SET);
            end
         end
         OP_FIND, OP_ALLOC: begin
            // window clipped to the map
            lim = (shadow_hi < MAP_BLOCKS) ? shadow_hi : MAP_BLOCKS;
            for (b = shadow_lo; b < lim && !hit; b++) begin
               if (!block_used(b)) begin
                  hit    = 1'b1;
                  hit_at = b;
               end
            end
            if (hit) begin
               a.block_number = hit_at[BLOCK_W-1:0];
               if (op == OP_ALLOC)
                  shadow_map[hit_at >> 5][31 - (hit_at & 31)] = 1'b1;
            end else begin
               a.block_number = '0;
               a.status       = ST_FULL;
            end
         end
         default: ;  // unused codes change nothing
      endcase
      return a;
   endfunction

   // driver: takes commands from the queue, predicts at acceptance
   always @(posedge clock) begin : drive_proc
      logic go;
      logic wr;
      if (reset) begin
         start      <= 1'b0;
         csr_wr_en  <= 1'b0;
         items_sent <= 0;
         for (int w = 0; w < MAP_WORDS; w++) shadow_map[w] = '0;
         shadow_lo = SEARCH_START_RST;
         shadow_hi = SEARCH_END_RST;
         idle_cnt  = 0;
         quiet_cnt = 0;
      end else begin
         go = start;
         wr = 1'b0;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SEARCH_START: shadow_lo = csr_wr_data;
               CSR_SEARCH_END:   shadow_hi = csr_wr_data;
               default: ;
            endcase
         end
         if (start && !busy) begin
            bitmap_answers.push_back(bitmap_apply(req_op, req_block));
            items_sent <= items_sent + 1;
            go = 1'b0;
         end
         // nothing in flight and the block idle
         if (items_sent == items_done && !busy && !start)
            quiet_cnt++;
         else
            quiet_cnt = 0;
         if (!go && alloc_cmds.size() != 0) begin
            case (alloc_cmds[0].kind)
               E_ITEM: begin
                  if (idle_cnt >= alloc_cmds[0].gap) begin
                     req_op    <= alloc_cmds[0].op;
                     req_block <= alloc_cmds[0].blk;
                     go = 1'b1;
                     idle_cnt = 0;
                     void'(alloc_cmds.pop_front());
                  end else begin
                     idle_cnt++;
                  end
               end
               E_CSR: begin
                  if (quiet_cnt >= SETTLE) begin
                     csr_index   <= alloc_cmds[0].idx;
                     csr_wr_data <= alloc_cmds[0].data;
                     wr = 1'b1;
                     void'(alloc_cmds.pop_front());
                  end
               end
               default: begin
                  if (quiet_cnt >= 1)
                     void'(alloc_cmds.pop_front());
               end
            endcase
         end
         start     <= go;
         csr_wr_en <= wr;
      end
   end

   // monitor: checks each strobed result against the oldest answer
   always @(posedge clock) begin : check_proc
      bitmap_answer_type want;
      if (reset) begin
         items_done <= 0;
         stall_cnt = 0;
      end else begin
         if (rsp_valid) begin
            if (items_done >= items_sent) begin
               errors++;
               $display("%0t: unexpected result bit %0d block %0d status %0d", $time,
                        rsp_bit_value, rsp_block_number, rsp_status);
            end else begin
               want = bitmap_answers.pop_front();
               items_done <= items_done + 1;
               if ({rsp_bit_value, rsp_block_number, rsp_status} !== want) begin
                  errors++;
                  $display("%0t: expected bit %0d blk %0d st %0d, got bit %0d blk %0d st %0d",
                           $time, want.bit_value, want.block_number, want.status,
                           rsp_bit_value, rsp_block_number, rsp_status);
               end
            end
         end
         // watchdog on traffic of any kind
         if ((start && !busy) || rsp_valid || csr_wr_en)
            stall_cnt = 0;
         else
            stall_cnt++;
         if (stall_cnt >= STALL_MAX) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic push_cmd(logic [OP_W-1:0] op, int unsigned blk);
      alloc_cmd_type c;
      c.kind = E_ITEM;
      c.op   = op;
      c.blk  = blk[BLOCK_W-1:0];
      c.idx  = '0;
      c.data = '0;
      c.gap  = burst ? 0 : $urandom_range(0, 13);
      alloc_cmds.push_back(c);
   endtask

   task automatic push_window(int unsigned lo, int unsigned hi);
      alloc_cmd_type c;
      c.kind = E_CSR;
      c.op   = OP_TEST;
      c.blk  = '0;
      c.gap  = 0;
      c.idx  = CSR_SEARCH_START;
      c.data = lo[CSR_DATA_W-1:0];
      alloc_cmds.push_back(c);
      c.idx  = CSR_SEARCH_END;
      c.data = hi[CSR_DATA_W-1:0];
      alloc_cmds.push_back(c);
      gen_lo = lo;
      gen_hi = hi;
   endtask

   task automatic push_drain();
      alloc_cmd_type c;
      c.kind = E_DRAIN;
      c.op   = OP_TEST;
      c.blk  = '0;
      c.idx  = '0;
      c.data = '0;
      c.gap  = 0;
      alloc_cmds.push_back(c);
   endtask

   // mostly blocks in and around the window, some near the map end, some anywhere
   function automatic int unsigned pick_block();
      int unsigned span;
      int unsigned v;
      case ($urandom_range(0, 9))
         0: v = $urandom_range(0, BLOCK_MAX);
         1: v = $urandom_range(MAP_BLOCKS - 8, MAP_BLOCKS + 7);
         default: begin
            span = (gen_hi > gen_lo) ? gen_hi - gen_lo : 1;
            v = gen_lo + $urandom_range(0, span + 3);
         end
      endcase
      return (v > BLOCK_MAX) ? BLOCK_MAX : v;
   endfunction

   task automatic run_mix(int unsigned n);
      int unsigned r;
      logic [OP_W-1:0] op;
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(0, 39) == 0)
            burst = !burst;
         r = $urandom_range(0, 99);
         if (r < 30)      op = OP_ALLOC;
         else if (r < 45) op = OP_FIND;
         else if (r < 65) op = OP_TEST;
         else if (r < 75) op = OP_SET;
         else if (r < 93) op = OP_CLEAR;
         else             op = OP_W'($urandom_range(OP_ALLOC + 1, (1 << OP_W) - 1));
         push_cmd(op, pick_block());
         if (n > 50 && i == n / 2 && $urandom_range(0, 1) == 0)
            push_drain();
      end
   endtask

   initial begin : stim_proc
      int unsigned lo;
      // directed part, reset window first
      push_cmd(OP_FIND, 0);
      push_cmd(OP_TEST, 0);
      push_cmd(OP_TEST, MAP_BLOCKS - 1);
      push_cmd(OP_TEST, MAP_BLOCKS);          // just past the map
      push_cmd(OP_SET, BLOCK_MAX);            // out of range
      push_cmd(OP_SET, 0);
      push_cmd(OP_SET, MAP_BLOCKS - 1);
      push_cmd(OP_TEST, 0);
      push_cmd(OP_CLEAR, 5);                  // already free
      push_cmd(OP_ALLOC, 0);
      push_cmd(OP_ALLOC, 0);
      push_cmd(OP_SET, 31);                   // word boundary
      push_cmd(OP_SET, 32);
      push_cmd(OP_TEST, 31);
      push_cmd(OP_CLEAR, BLOCK_MAX);
      push_cmd(OP_W'(OP_ALLOC + 1), BLOCK_MAX);    // unused codes
      push_cmd(OP_W'((1 << OP_W) - 1), 0);
      push_cmd(OP_W'(OP_ALLOC + 2), $urandom_range(0, BLOCK_MAX));
      push_window(0, 0);                      // empty window
      push_cmd(OP_ALLOC, 0);
      push_window(MAP_BLOCKS - 1, MAP_BLOCKS); // one block, already used
      push_cmd(OP_ALLOC, 0);
      push_cmd(OP_CLEAR, MAP_BLOCKS - 1);
      push_cmd(OP_ALLOC, 0);
      push_window(0, BLOCK_MAX);              // end clipped to the map
      push_cmd(OP_FIND, 0);
      push_window(BLOCK_MAX, BLOCK_MAX);
      push_cmd(OP_FIND, 0);
      push_window(200, 100);                  // start past end
      push_cmd(OP_ALLOC, 0);
      push_window(MAP_BLOCKS - 1, BLOCK_MAX);
      push_cmd(OP_FIND, 0);
      push_drain();

      // random part, a new window per phase
      for (int p = 0; p < 10; p++) begin
         case (p % 4)
            0: begin
               lo = $urandom_range(0, MAP_BLOCKS - 1);
               push_window(lo, lo + $urandom_range(1, 48));
            end
            1: push_window($urandom_range(0, 2000), $urandom_range(8000, MAP_BLOCKS));
            2: push_window($urandom_range(0, BLOCK_MAX), $urandom_range(0, BLOCK_MAX));
            default: push_window(SEARCH_START_RST, SEARCH_END_RST);
         endcase
         run_mix(100);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      forever begin
         @(negedge clock);
         if (alloc_cmds.size() == 0 && !start && items_sent == items_done)
            break;
      end
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0 && bitmap_answers.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
